[rtl/core/qfa_pkg.sv]
// Package for the fixed-point ALU core: operation codes, status codes,
// default widths and the control struct carried down the divider chain.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qfa_pkg;

   localparam int FRAC_BITS_DEF = 8;
   localparam int WORD_BITS_DEF = 32;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_DIV    = 4'd3,
      OP_GT     = 4'd4,
      OP_LT     = 4'd5,
      OP_GE     = 4'd6,
      OP_LE     = 4'd7,
      OP_EQ     = 4'd8,
      OP_NE     = 4'd9,
      OP_MIN    = 4'd10,
      OP_MAX    = 4'd11,
      OP_INC    = 4'd12,
      OP_DEC    = 4'd13,
      OP_TO_INT = 4'd14
   } op_type;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_DIVERR = 2'd1;
   localparam logic [1:0] ST_SAT    = 2'd2;

   typedef struct packed {
      logic       is_mul;
      logic       is_div;
      logic       neg;
      logic       flag;
      logic [1:0] status;
   } ctrl_type;

endpackage
`default_nettype wire

[rtl/core/qfa_if.sv]
// Valid/ready channel interfaces for request and response items.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface qfa_req_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic [3:0]                  operation;
   logic signed [WORD_BITS-1:0] operand_a;
   logic signed [WORD_BITS-1:0] operand_b;
   modport source (output valid, operation, operand_a, operand_b, input ready);
   modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface qfa_rsp_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] result_value;
   logic                        compare_flag;
   logic [1:0]                  status;
   modport source (output valid, result_value, compare_flag, status, input ready);
   modport sink   (input valid, result_value, compare_flag, status, output ready);
endinterface
`default_nettype wire

[rtl/core/qfa_prep.sv]
// Front stage: ops computed directly here, multiplier, divider operand setup.
// Depends on qfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qfa_prep import qfa_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF,
   localparam int NB = WORD_BITS + FRAC_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   valid,
   input  wire logic [3:0]             operation,
   input  wire logic [WORD_BITS-1:0]   operand_a,
   input  wire logic [WORD_BITS-1:0]   operand_b,
   output logic                        valid_ff,
   output ctrl_type                    ctrl_ff,
   output logic [NB-1:0]               nq_ff,
   output logic [WORD_BITS-1:0]        den_ff,
   output logic [2*WORD_BITS-1:0]      res_ff
);
   localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   logic signed [WORD_BITS-1:0] sa, sb;
   logic [WORD_BITS:0]          sum, dif;
   logic [WORD_BITS-1:0]        ma, mb, r;
   logic                        lt, gt;
   ctrl_type                    ctrl_in;
   logic [2*WORD_BITS-1:0]      res_in;

   always_comb begin
      sa  = operand_a;
      sb  = operand_b;
      lt  = sa < sb;
      gt  = sb < sa;
      sum = {operand_a[WORD_BITS-1], operand_a} + {operand_b[WORD_BITS-1], operand_b};
      dif = {operand_a[WORD_BITS-1], operand_a} - {operand_b[WORD_BITS-1], operand_b};
      ma  = operand_a[WORD_BITS-1] ? ~operand_a + 1'b1 : operand_a;
      mb  = operand_b[WORD_BITS-1] ? ~operand_b + 1'b1 : operand_b;
      r       = '0;
      ctrl_in = '0;
      res_in  = '0;
      unique case (operation)
         OP_ADD: begin
            if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
               ctrl_in.status = ST_SAT;
               r = sum[WORD_BITS] ? WMIN : WMAX;
            end else r = sum[WORD_BITS-1:0];
         end
         OP_SUB: begin
            if (dif[WORD_BITS] != dif[WORD_BITS-1]) begin
               ctrl_in.status = ST_SAT;
               r = dif[WORD_BITS] ? WMIN : WMAX;
            end else r = dif[WORD_BITS-1:0];
         end
         OP_MUL: begin
            ctrl_in.is_mul = 1'b1;
            ctrl_in.neg    = operand_a[WORD_BITS-1] ^ operand_b[WORD_BITS-1];
         end
         OP_DIV: begin
            ctrl_in.is_div = 1'b1;
            ctrl_in.neg    = operand_a[WORD_BITS-1];
            if (operand_b[WORD_BITS-1] || operand_b == '0) ctrl_in.status = ST_DIVERR;
         end
         OP_GT: ctrl_in.flag = gt;
         OP_LT: ctrl_in.flag = lt;
         OP_GE: ctrl_in.flag = !lt;
         OP_LE: ctrl_in.flag = !gt;
         OP_EQ: ctrl_in.flag = operand_a == operand_b;
         OP_NE: ctrl_in.flag = operand_a != operand_b;
         OP_MIN: r = lt ? operand_a : operand_b;
         OP_MAX: r = gt ? operand_a : operand_b;
         OP_INC: begin
            if (operand_a == WMAX) begin
               ctrl_in.status = ST_SAT;
               r = operand_a;
            end else r = operand_a + 1'b1;
         end
         OP_DEC: begin
            if (operand_a == WMIN) begin
               ctrl_in.status = ST_SAT;
               r = operand_a;
            end else r = operand_a - 1'b1;
         end
         OP_TO_INT: r = WORD_BITS'(sa >>> FRAC_BITS);
         default: r = '0;
      endcase
      if (ctrl_in.is_mul) res_in = ma * mb;
      else res_in = {{WORD_BITS{1'b0}}, r};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid;
      end
      if (en) begin
         ctrl_ff <= ctrl_in;
         res_ff  <= res_in;
         nq_ff   <= {ma, {FRAC_BITS{1'b0}}};
         den_ff  <= operand_b;
      end
   end
endmodule
`default_nettype wire

[rtl/core/qfa_cell.sv]
// One restoring-division cell: one quotient bit, carries the item onward.
// Depends on qfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qfa_cell import qfa_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF,
   localparam int NB = WORD_BITS + FRAC_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   valid_in,
   input  wire ctrl_type               ctrl_in,
   input  wire logic [WORD_BITS-1:0]   rem_in,
   input  wire logic [NB-1:0]          nq_in,
   input  wire logic [WORD_BITS-1:0]   den_in,
   input  wire logic [2*WORD_BITS-1:0] res_in,
   output logic                        valid_ff,
   output ctrl_type                    ctrl_ff,
   output logic [WORD_BITS-1:0]        rem_ff,
   output logic [NB-1:0]               nq_ff,
   output logic [WORD_BITS-1:0]        den_ff,
   output logic [2*WORD_BITS-1:0]      res_ff
);
   logic [WORD_BITS-1:0] sh;
   logic                 ge;

   always_comb begin
      sh = {rem_in[WORD_BITS-2:0], nq_in[NB-1]};
      ge = sh >= den_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         ctrl_ff <= ctrl_in;
         rem_ff  <= ge ? sh - den_in : sh;
         nq_ff   <= {nq_in[NB-2:0], ge};
         den_ff  <= den_in;
         res_ff  <= res_in;
      end
   end
endmodule
`default_nettype wire

[rtl/core/qfa_post.sv]
// Final rounding and saturation of multiply and divide; result select.
// Depends on qfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qfa_post import qfa_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF,
   localparam int NB = WORD_BITS + FRAC_BITS
) (
   input  wire ctrl_type               ctrl,
   input  wire logic [WORD_BITS-1:0]   rem,
   input  wire logic [NB-1:0]          nq,
   input  wire logic [WORD_BITS-1:0]   den,
   input  wire logic [2*WORD_BITS-1:0] res,
   output logic [WORD_BITS-1:0]        result_value,
   output logic                        compare_flag,
   output logic [1:0]                  status
);
   localparam int MW = 2*WORD_BITS + 1 - FRAC_BITS;
   localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [2*WORD_BITS:0] HALF = (2*WORD_BITS+1)'(1) << (FRAC_BITS-1);
   localparam logic [MW-1:0] MLIM = MW'(1) << (WORD_BITS-1);
   localparam logic [NB:0]   QLIM = (NB+1)'(1) << (WORD_BITS-1);

   logic [2*WORD_BITS:0] psum;
   logic [MW-1:0]        mq;
   logic [NB:0]          q;
   logic                 rnd, msat, qsat;

   always_comb begin
      psum = {1'b0, res} + HALF;
      mq   = psum[2*WORD_BITS:FRAC_BITS];
      msat = ctrl.neg ? mq > MLIM : mq >= MLIM;
      rnd  = {rem, 1'b0} >= {1'b0, den};
      q    = {1'b0, nq} + (NB+1)'(rnd);
      qsat = ctrl.neg ? q > QLIM : q >= QLIM;
      compare_flag = ctrl.flag;
      status       = ctrl.status;
      result_value = res[WORD_BITS-1:0];
      if (ctrl.is_mul) begin
         if (msat) begin
            status       = ST_SAT;
            result_value = ctrl.neg ? WMIN : WMAX;
         end else result_value = ctrl.neg ? ~mq[WORD_BITS-1:0] + 1'b1 : mq[WORD_BITS-1:0];
      end else if (ctrl.is_div) begin
         if (ctrl.status == ST_DIVERR) result_value = '0;
         else if (qsat) begin
            status       = ST_SAT;
            result_value = ctrl.neg ? WMIN : WMAX;
         end else result_value = ctrl.neg ? ~q[WORD_BITS-1:0] + 1'b1 : q[WORD_BITS-1:0];
      end
   end
endmodule
`default_nettype wire

[rtl/core/q24_8_fixed_point_alu_core.sv]
// Top level of the Q24.8 fixed-point ALU: front stage, division cell chain,
// output register. Depends on qfa_pkg, qfa_if, qfa_prep, qfa_cell, qfa_post.
//
//   channel  | dir | contents
//   req_if   | in  | operation, operand_a, operand_b
//   rsp_if   | out | result_value, compare_flag, status
//
// One item per cycle while rsp is not stalled; every op passes the front-stage
// register, the chain of one-bit division cells and the output register. The
// whole pipeline advances when the output register is empty or being taken; a
// stalled rsp freezes it. Synchronous reset clears valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module q24_8_fixed_point_alu_core import qfa_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   qfa_req_if.sink  req_if,
   qfa_rsp_if.source rsp_if
);
   localparam int NB = WORD_BITS + FRAC_BITS;

   logic                   en;
   logic                   v_w   [0:NB];
   ctrl_type               c_w   [0:NB];
   logic [WORD_BITS-1:0]   rem_w [0:NB];
   logic [NB-1:0]          nq_w  [0:NB];
   logic [WORD_BITS-1:0]   den_w [0:NB];
   logic [2*WORD_BITS-1:0] res_w [0:NB];
   logic [WORD_BITS-1:0]   rv;
   logic                   cf;
   logic [1:0]             st;
   logic                   out_valid_ff;
   logic [WORD_BITS-1:0]   out_value_ff;
   logic                   out_flag_ff;
   logic [1:0]             out_status_ff;

   assign en           = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = en;
   assign rem_w[0]     = '0;

   qfa_prep #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_prep (
      .clock, .reset, .en,
      .valid(req_if.valid), .operation(req_if.operation),
      .operand_a(req_if.operand_a), .operand_b(req_if.operand_b),
      .valid_ff(v_w[0]), .ctrl_ff(c_w[0]), .nq_ff(nq_w[0]),
      .den_ff(den_w[0]), .res_ff(res_w[0])
   );

   for (genvar i = 0; i < NB; i++) begin : g_cell
      qfa_cell #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_cell (
         .clock, .reset, .en,
         .valid_in(v_w[i]), .ctrl_in(c_w[i]), .rem_in(rem_w[i]),
         .nq_in(nq_w[i]), .den_in(den_w[i]), .res_in(res_w[i]),
         .valid_ff(v_w[i+1]), .ctrl_ff(c_w[i+1]), .rem_ff(rem_w[i+1]),
         .nq_ff(nq_w[i+1]), .den_ff(den_w[i+1]), .res_ff(res_w[i+1])
      );
   end

   qfa_post #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_post (
      .ctrl(c_w[NB]), .rem(rem_w[NB]), .nq(nq_w[NB]), .den(den_w[NB]),
      .res(res_w[NB]), .result_value(rv), .compare_flag(cf), .status(st)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= v_w[NB];
      end
      if (en) begin
         out_value_ff  <= rv;
         out_flag_ff   <= cf;
         out_status_ff <= st;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.result_value = out_value_ff;
   assign rsp_if.compare_flag = out_flag_ff;
   assign rsp_if.status       = out_status_ff;
endmodule
`default_nettype wire

[tb/sv/qfa_tb_pkg.sv]
// Testbench package for the Q24.8 ALU: a shared helper, pick_word, for stimulus.
// Depends on qfa_pkg.
`timescale 1ns / 1ps
package qfa_tb_pkg;
   import qfa_pkg::*;

   function automatic logic [31:0] pick_word(input int unsigned sel);
      case (sel % 8)
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return $urandom_range(0, 1023) - 512;
         4: return $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
         5: return {{16{1'b0}}, 16'($urandom)} ^ {32{1'($urandom)}};
         default: return $urandom;
      endcase
   endfunction
endpackage

[tb/sv/qfa_tb_if.sv]
// Valid/ready interface instances are taken from the RTL; this file holds a
// single quiet flag that switches off the random idling of the testbench top.
// Depends on nothing.
`timescale 1ns / 1ps
interface qfa_idle_if;
   logic quiet;
endinterface

[tb/sv/qfa_checker.sv]
// Scoreboard for the Q24.8 ALU: watches request and response channels,
// predicts each result with exact integer arithmetic and compares fields.
// Depends on qfa_pkg and the channel interfaces.
`timescale 1ns / 1ps
module qfa_checker import qfa_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   qfa_req_if req_if,
   qfa_rsp_if rsp_if,
   output int fail_count,
   output int pending_count,
   output int result_count
);
   typedef struct packed {
      logic signed [31:0] value;
      logic               flag;
      logic [1:0]         status;
   } alu_result_type;

   alu_result_type expected_results[$];

   localparam logic signed [63:0] WORD_MAX = 64'sh7FFF_FFFF;
   localparam logic signed [63:0] WORD_MIN = -64'sh8000_0000;

   function automatic alu_result_type saturate(input logic signed [127:0] v);
      alu_result_type r;
      r = '0;
      if (v > WORD_MAX) begin
         r.value = 32'h7FFF_FFFF;
         r.status = ST_SAT;
      end else if (v < WORD_MIN) begin
         r.value = 32'h8000_0000;
         r.status = ST_SAT;
      end else begin
         r.value = v[31:0];
      end
      return r;
   endfunction

   function automatic alu_result_type predict_alu(input logic [3:0] op,
                                                  input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      alu_result_type r;
      logic signed [127:0] wa, wb, p, q;
      logic [127:0] ma, mq, rm;
      logic neg;
      r = '0;
      wa = a;
      wb = b;
      case (op)
         OP_ADD: r = saturate(wa + wb);
         OP_SUB: r = saturate(wa - wb);
         OP_MUL: begin
            p = wa * wb;
            neg = p < 0;
            ma = neg ? -p : p;
            mq = (ma + 128'd128) >> 8;
            r = saturate(neg ? -$signed(mq) : $signed(mq));
         end
         OP_DIV: begin
            if (b <= 0) begin
               r.status = ST_DIVERR;
            end else begin
               ma = (wa < 0 ? -wa : wa) << 8;
               mq = ma / wb;
               rm = ma % wb;
               if (2 * rm >= wb) mq = mq + 1;
               q = (a < 0) ? -$signed(mq) : $signed(mq);
               r = saturate(q);
            end
         end
         OP_GT: r.flag = a > b;
         OP_LT: r.flag = a < b;
         OP_GE: r.flag = a >= b;
         OP_LE: r.flag = a <= b;
         OP_EQ: r.flag = a == b;
         OP_NE: r.flag = a != b;
         OP_MIN: r.value = (a < b) ? a : b;
         OP_MAX: r.value = (a > b) ? a : b;
         OP_INC: r = saturate(wa + 1);
         OP_DEC: r = saturate(wa - 1);
         OP_TO_INT: r.value = a >>> 8;
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      result_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      alu_result_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            expected_results.push_back(predict_alu(req_if.operation, req_if.operand_a,
                                                   req_if.operand_b));
         if (rsp_if.valid && rsp_if.ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected item", rsp_if.result_value, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.result_value !== want.value)
                  report_mismatch("result_value", rsp_if.result_value, want.value);
               if (rsp_if.compare_flag !== want.flag)
                  report_mismatch("compare_flag", rsp_if.compare_flag, want.flag);
               if (rsp_if.status !== want.status)
                  report_mismatch("status", rsp_if.status, want.status);
            end
         end
      end
      pending_count = expected_results.size();
   end
endmodule

[tb/sv/testbench.sv]
// Top of the Q24.8 ALU testbench: clock, reset, directed and random
// stimulus with random idling, verdict. Depends on qfa_pkg, qfa_tb_pkg,
// the channel interfaces, the idle interface, qfa_checker and the core.
`timescale 1ns / 1ps
module testbench;
   import qfa_pkg::*;
   import qfa_tb_pkg::*;

   localparam int ITEM_TOTAL = 1850;
   localparam int DRAIN_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int fail_count, pending_count, result_count;
   int idle_cycles = 0;
   int sent = 0;

   qfa_req_if req_if ();
   qfa_rsp_if rsp_if ();
   qfa_idle_if idle_ctl ();

   always #10 clock = ~clock;

   q24_8_fixed_point_alu_core dut (.clock(clock), .reset(reset),
                                   .req_if(req_if), .rsp_if(rsp_if));

   qfa_checker scoreboard (.clock(clock), .reset(reset), .req_if(req_if),
                           .rsp_if(rsp_if), .fail_count(fail_count),
                           .pending_count(pending_count), .result_count(result_count));

   initial begin
      idle_ctl.quiet = 1'b0;
      req_if.valid = 1'b0;
      req_if.operation = '0;
      req_if.operand_a = '0;
      req_if.operand_b = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d items outstanding", pending_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side stalls in random bursts
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
         if (!idle_ctl.quiet && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 12);
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   task automatic send_item(input logic [3:0] op, input logic [31:0] a,
                            input logic [31:0] b);
      if (!idle_ctl.quiet && $urandom_range(0, 9) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.operation <= op;
      req_if.operand_a <= a;
      req_if.operand_b <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   initial begin
      int unsigned op;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k <= 15; k++)
         send_item(k[3:0], 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
      send_item(OP_SUB, 32'h8000_0000, 32'h0000_0001);
      send_item(OP_MUL, 32'h0000_0180, 32'hFFFF_FF80);
      send_item(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(OP_DIV, 32'h0000_0100, 32'h0000_0000);
      send_item(OP_DIV, 32'h8000_0000, 32'h0000_0001);
      send_item(OP_DIV, 32'hFFFF_FE80, 32'h0000_0200);
      send_item(OP_MIN, 32'h1234_5678, 32'h1234_5678);
      send_item(OP_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_DEC, 32'h8000_0000, 32'h0);
      send_item(OP_TO_INT, 32'hFFFF_FF01, 32'h0);

      while (sent < ITEM_TOTAL) begin
         if (sent > ITEM_TOTAL - 200) idle_ctl.quiet = 1'b1;
         op = $urandom_range(0, 15);
         send_item(op[3:0], pick_word($urandom), pick_word($urandom));
      end
      req_if.valid <= 1'b0;
      idle_ctl.quiet = 1'b1;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d items over all operation codes, %0d results checked,", sent,
               result_count);
      $display("including saturation, divide errors and random stalls.");
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
